// File: hdl/bxf_pkg.sv
// Shared constants and types for the 3x3 box filter.
`timescale 1ns / 1ps

package bxf_pkg;

  // Default sizes handed to the top level.
  localparam int MAX_WIDTH_DEF   = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  // Register file geometry.
  localparam int CFG_BITS     = 9;
  localparam int CFG_IDX_BITS = 1;

  // Register reset values and limits.
  localparam int GRID_WIDTH_RESET  = 150;
  localparam int GRID_HEIGHT_RESET = 150;
  localparam int GRID_MIN          = 3;
  localparam int MAX_HEIGHT        = 256;

  // Row and column tags on results.
  localparam int COORD_BITS = 8;

  // Pipeline depth of the divide-by-nine unit.
  localparam int DIV_LAT = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_idx_t;

  // Result slots of one input item, in delivery order.
  typedef enum logic [1:0] {
    SLOT_CENTER = 2'd0,  // (r-1, c-1): mean or border pass-through
    SLOT_RIGHT  = 2'd1,  // (r-1, c)  : last column
    SLOT_BELOW  = 2'd2,  // (r, c-1)  : last row
    SLOT_CORNER = 2'd3   // (r, c)    : last grid position
  } slot_t;

endpackage

// File: hdl/bxf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bxf_ram import bxf_pkg::*; #(
  parameter int WIDTH = SAMPLE_BITS_DEF,
  parameter int DEPTH = MAX_WIDTH_DEF,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/bxf_div9.sv
// Pipelined signed divide by nine, rounding to nearest, ties away from zero.
`timescale 1ns / 1ps

module bxf_div9 import bxf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS+3:0] sum_in,
  output logic signed [SAMPLE_BITS-1:0] mean_out
);

  localparam int SUM_BITS  = SAMPLE_BITS + 4;
  localparam int MAG_BITS  = SAMPLE_BITS + 3;
  localparam int SHIFT     = MAG_BITS + 3;
  localparam int LO_BITS   = MAG_BITS / 2;
  localparam int HI_BITS   = MAG_BITS - LO_BITS;
  localparam int PLO_BITS  = LO_BITS + MAG_BITS;
  localparam int PHI_BITS  = HI_BITS + MAG_BITS;
  localparam int PROD_BITS = 2 * MAG_BITS;

  // ceil(2^SHIFT / 9): exact floor quotient for every magnitude below 2^MAG_BITS.
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'd8) / 64'd9;
  localparam logic [MAG_BITS-1:0] RECIP = RECIP_FULL[MAG_BITS-1:0];

  logic [SUM_BITS-1:0]    sum_u;
  logic [SUM_BITS-1:0]    mag_full;
  logic [MAG_BITS-1:0]    mag_r;
  logic                   neg1_r, neg2_r, neg3_r;
  logic [PLO_BITS-1:0]    plo_r, plo_nxt;
  logic [PHI_BITS-1:0]    phi_r, phi_nxt;
  logic [PROD_BITS-1:0]   prod;
  logic [SAMPLE_BITS-1:0] q_r;
  logic [SAMPLE_BITS-1:0] mean_r;

  // Magnitude plus the rounding half: |sum| + 4.
  assign sum_u    = sum_in;
  assign mag_full = sum_u[SUM_BITS-1] ? (~sum_u + SUM_BITS'(5)) : (sum_u + SUM_BITS'(4));

  // Split the reciprocal multiply into two partial products.
  assign plo_nxt = PLO_BITS'(mag_r[LO_BITS-1:0]) * PLO_BITS'(RECIP);
  assign phi_nxt = PHI_BITS'(mag_r[MAG_BITS-1:LO_BITS]) * PHI_BITS'(RECIP);

  assign prod = (PROD_BITS'(phi_r) << LO_BITS) + PROD_BITS'(plo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= mag_full[MAG_BITS-1:0];
      neg1_r <= sum_u[SUM_BITS-1];
      plo_r  <= plo_nxt;
      phi_r  <= phi_nxt;
      neg2_r <= neg1_r;
      q_r    <= prod[SHIFT +: SAMPLE_BITS];
      neg3_r <= neg2_r;
      mean_r <= neg3_r ? (~q_r + SAMPLE_BITS'(1)) : q_r;
    end
  end

  assign mean_out = mean_r;

endmodule

// File: hdl/box_filter_3x3_grid.sv
// Top level of the 3x3 box filter over a raster-ordered height grid.
//
//   channel  direction  handshake              payload
//   in_      in         in_valid / in_stall    in_sample_in
//   out_     out        out_valid / out_stall  out_sample_out, out_row, out_col,
//                                              out_last_of_run, out_frame_done
//   cfg_     in         cfg_we                 cfg_index, cfg_wdata
//
// One item enters per cycle while results flow and the output is not stalled; an item
// yields 0 to 4 results and the single result register drains one per cycle, so an item on
// the last column, each item of the last row and the final one hold the input until it drains.
// An accepted item reaches its first result through the RAM read, window, sum, four divider
// stages and result register. Synchronous active-low reset clears counters, pipeline valids
// and the window; the row stores need no clearing pass.
// Stall on the output freezes the whole pipeline and raises in_stall.
`timescale 1ns / 1ps

module box_filter_3x3_grid import bxf_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic [COORD_BITS-1:0]         out_row,
  output logic [COORD_BITS-1:0]         out_col,
  output logic                          out_last_of_run,
  output logic                          out_frame_done,
  // configuration
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_BITS-1:0]           cfg_wdata
);

  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int CMP_BITS   = (COL_BITS + 1 > CFG_BITS) ? COL_BITS + 1 : CFG_BITS;
  localparam int CSUM_BITS  = SAMPLE_BITS + 2;
  localparam int SUM_BITS   = SAMPLE_BITS + 4;
  localparam int META_DEPTH = 2 + DIV_LAT;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Everything an item carries alongside the mean computation.
  typedef struct packed {
    logic                  valid;
    logic                  emit;
    logic                  interior;
    logic                  last_col;
    logic                  last_row;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    sample_t               center;
    sample_t               right;
    sample_t               below;
    sample_t               corner;
  } meta_t;

  // ---------------------------------------------------------------------------
  // Configuration registers and effective grid limits
  // ---------------------------------------------------------------------------
  logic [CFG_BITS-1:0] grid_width_r, grid_height_r;
  logic [CMP_BITS-1:0] gw_ext;
  logic [COL_BITS-1:0] col_last;
  logic [COORD_BITS-1:0] row_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= CFG_BITS'(GRID_WIDTH_RESET);
      grid_height_r <= CFG_BITS'(GRID_HEIGHT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
      endcase
    end
  end

  // Clamp width to [3, MAX_WIDTH] and height to [3, 256], expressed as last index.
  assign gw_ext = CMP_BITS'(grid_width_r);

  always_comb begin
    priority if (gw_ext < CMP_BITS'(GRID_MIN)) begin
      col_last = COL_BITS'(GRID_MIN - 1);
    end else if (gw_ext > CMP_BITS'(MAX_WIDTH)) begin
      col_last = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_BITS'(gw_ext - CMP_BITS'(1));
    end
  end

  always_comb begin
    priority if (grid_height_r < CFG_BITS'(GRID_MIN)) begin
      row_last = COORD_BITS'(GRID_MIN - 1);
    end else if (grid_height_r > CFG_BITS'(MAX_HEIGHT)) begin
      row_last = COORD_BITS'(MAX_HEIGHT - 1);
    end else begin
      row_last = COORD_BITS'(grid_height_r - CFG_BITS'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline advance
  // ---------------------------------------------------------------------------
  logic [3:0] pend_r, pend_nxt, load_mask;
  logic       adv, in_take, out_take, one_left;

  assign out_valid = |pend_r;
  assign out_take  = out_valid & ~out_stall;
  assign one_left  = (pend_r & (pend_r - 4'd1)) == 4'd0;
  // The whole pipeline moves when the result register is empty or handing off its last.
  assign adv       = (pend_r == 4'd0) || (out_take && one_left);
  assign in_stall  = ~adv;
  assign in_take   = in_valid & adv;

  // ---------------------------------------------------------------------------
  // Stage A: position counters, row store read
  // ---------------------------------------------------------------------------
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [COL_BITS-1:0]   col_r, col_nxt;
  logic                  at_last_col, at_last_row;

  assign at_last_col = (col_r == col_last);
  assign at_last_row = (row_r == row_last);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (at_last_col) begin
      col_nxt = '0;
      row_nxt = at_last_row ? '0 : row_r + COORD_BITS'(1);
    end else begin
      col_nxt = col_r + COL_BITS'(1);
    end
  end

  // Any register write starts a new grid.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_take) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: store data arrives, rotate the stores, shift the window
  // ---------------------------------------------------------------------------
  logic                  b_valid_r;
  sample_t               b_x_r;
  logic [COORD_BITS-1:0] b_row_r;
  logic [COL_BITS-1:0]   b_col_r;
  logic                  b_last_col_r, b_last_row_r;
  logic [SAMPLE_BITS-1:0] older_rd, newer_rd;
  logic                  b_write;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      b_x_r        <= in_sample_in;
      b_row_r      <= row_r;
      b_col_r      <= col_r;
      b_last_col_r <= at_last_col;
      b_last_row_r <= at_last_row;
    end
  end

  // Older row takes what the newer row held; newer row takes the new sample.
  // The next read is at another column, so no forwarding is needed.
  assign b_write = adv & b_valid_r;

  bxf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_older_ram (
    .clk   (clk),
    .we    (b_write),
    .waddr (b_col_r),
    .wdata (newer_rd),
    .re    (in_take),
    .raddr (col_r),
    .rdata (older_rd)
  );

  bxf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_newer_ram (
    .clk   (clk),
    .we    (b_write),
    .waddr (b_col_r),
    .wdata (b_x_r),
    .re    (in_take),
    .raddr (col_r),
    .rdata (newer_rd)
  );

  // Window kept as three column sums plus the previous middle and bottom samples.
  logic signed [CSUM_BITS-1:0] colsum_r [3];
  logic signed [CSUM_BITS-1:0] colsum_new;
  sample_t                     prev_mid_r, prev_bot_r;
  sample_t                     above2, above1;
  meta_t                       meta_b;
  meta_t                       meta_r [META_DEPTH];

  assign above2     = older_rd;
  assign above1     = newer_rd;
  assign colsum_new = CSUM_BITS'(above2) + CSUM_BITS'(above1) + CSUM_BITS'(b_x_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colsum_r[0] <= '0;
      colsum_r[1] <= '0;
      colsum_r[2] <= '0;
      prev_mid_r  <= '0;
      prev_bot_r  <= '0;
    end else if (b_write) begin
      colsum_r[0] <= colsum_r[1];
      colsum_r[1] <= colsum_r[2];
      colsum_r[2] <= colsum_new;
      prev_mid_r  <= above1;
      prev_bot_r  <= b_x_r;
    end
  end

  always_comb begin
    meta_b.valid    = b_valid_r;
    meta_b.emit     = (b_row_r != '0) && (b_col_r != '0);
    meta_b.interior = (b_row_r >= COORD_BITS'(2)) && (b_col_r >= COL_BITS'(2));
    meta_b.last_col = b_last_col_r;
    meta_b.last_row = b_last_row_r;
    meta_b.row      = b_row_r;
    meta_b.col      = COORD_BITS'(b_col_r);
    meta_b.center   = prev_mid_r;   // window center after the shift
    meta_b.right    = above1;
    meta_b.below    = prev_bot_r;
    meta_b.corner   = b_x_r;
  end

  // ---------------------------------------------------------------------------
  // Stages C..H: neighborhood sum, then divide by nine
  // ---------------------------------------------------------------------------
  logic signed [SUM_BITS-1:0]    sum_r;
  logic signed [SAMPLE_BITS-1:0] div_mean;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < META_DEPTH; i++) begin
        meta_r[i] <= '0;
      end
    end else if (adv) begin
      meta_r[0] <= meta_b;
      for (int i = 1; i < META_DEPTH; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= SUM_BITS'(colsum_r[0]) + SUM_BITS'(colsum_r[1]) + SUM_BITS'(colsum_r[2]);
    end
  end

  bxf_div9 #(.SAMPLE_BITS(SAMPLE_BITS)) u_div9 (
    .clk      (clk),
    .en       (adv),
    .sum_in   (sum_r),
    .mean_out (div_mean)
  );

  // ---------------------------------------------------------------------------
  // Result register: up to four results of one item, drained lowest slot first
  // ---------------------------------------------------------------------------
  meta_t                 head;
  sample_t               t_center_r, t_right_r, t_below_r, t_corner_r;
  logic [COORD_BITS-1:0] t_row_r, t_col_r;
  slot_t                 sel;

  assign head      = meta_r[META_DEPTH-1];
  assign load_mask = {head.last_row & head.last_col, head.last_row, head.last_col, 1'b1}
                     & {4{head.valid & head.emit}};

  always_comb begin
    pend_nxt = pend_r;
    if (adv) begin
      pend_nxt = load_mask;
    end else if (out_take) begin
      pend_nxt = pend_r & (pend_r - 4'd1);  // drop the slot just delivered
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // Hold payload until the next bundle loads.
  always_ff @(posedge clk) begin
    if (adv) begin
      t_center_r <= head.interior ? div_mean : head.center;
      t_right_r  <= head.right;
      t_below_r  <= head.below;
      t_corner_r <= head.corner;
      t_row_r    <= head.row;
      t_col_r    <= head.col;
    end
  end

  always_comb begin
    priority if (pend_r[0]) begin
      sel = SLOT_CENTER;
    end else if (pend_r[1]) begin
      sel = SLOT_RIGHT;
    end else if (pend_r[2]) begin
      sel = SLOT_BELOW;
    end else begin
      sel = SLOT_CORNER;
    end
  end

  always_comb begin
    unique case (sel)
      SLOT_CENTER: begin
        out_sample_out = t_center_r;
        out_row        = t_row_r - COORD_BITS'(1);
        out_col        = t_col_r - COORD_BITS'(1);
      end
      SLOT_RIGHT: begin
        out_sample_out = t_right_r;
        out_row        = t_row_r - COORD_BITS'(1);
        out_col        = t_col_r;
      end
      SLOT_BELOW: begin
        out_sample_out = t_below_r;
        out_row        = t_row_r;
        out_col        = t_col_r - COORD_BITS'(1);
      end
      SLOT_CORNER: begin
        out_sample_out = t_corner_r;
        out_row        = t_row_r;
        out_col        = t_col_r;
      end
    endcase
  end

  assign out_last_of_run = one_left;
  assign out_frame_done  = (sel == SLOT_CORNER);

endmodule

// File: hdl/bxf_checker.sv
// Port-level checks for the box filter, bound to the top level.
`timescale 1ns / 1ps

module bxf_checker import bxf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input logic [COORD_BITS-1:0]         out_row,
  input logic [COORD_BITS-1:0]         out_col,
  input logic                          out_last_of_run,
  input logic                          out_frame_done
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // The last grid position always closes its run.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_last_of_run)
    else $error("frame_done without last_of_run");

  // A blocked result blocks the input.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input open while result is stalled");

  // Taking a result that is not the last of its run leaves the next one ready.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("run ended early");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out) && $stable(out_row)
                               && $stable(out_col))
    else $error("stalled result changed");

endmodule

bind box_filter_3x3_grid bxf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_bxf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_sample_out  (out_sample_out),
  .out_row         (out_row),
  .out_col         (out_col),
  .out_last_of_run (out_last_of_run),
  .out_frame_done  (out_frame_done)
);

// File: tb/sv/box_filter_3x3_grid_test.sv
// Self-checking testbench for the 3x3 box filter: raster grids in, tagged samples checked.
`timescale 1ns / 1ps

module box_filter_3x3_grid_test;
  import bxf_pkg::*;

  localparam int SW            = SAMPLE_BITS_DEF;
  localparam int CYCLE_LIMIT   = 500000;  // far beyond the slowest legal run
  localparam int SETTLE_CYCLES = 20;      // covers the first-result latency, with margin
  localparam int LONG_HOLD     = 150;     // receiver hold-off that backs up the pipeline

  typedef logic signed [SW-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

  // One entry of the send queue: a sample, or a marker that holds the sender
  // until every result due so far has arrived.
  typedef struct {
    bit      pause;
    sample_t value;
  } feed_item_t;

  // One expected result of the filter.
  typedef struct {
    sample_t               value;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic                  last;
    logic                  done;
  } smoothed_t;

  // Clock, reset and block ports; every input is known from time zero.
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  sample_t               in_sample_in = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sample_t               out_sample_out;
  logic [COORD_BITS-1:0] out_row;
  logic [COORD_BITS-1:0] out_col;
  logic                  out_last_of_run;
  logic                  out_frame_done;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = CFG_GRID_WIDTH;
  logic [CFG_BITS-1:0]   cfg_wdata = '0;

  // Send queue, results due, and bookkeeping shared by the processes.
  feed_item_t samples_to_send[$];
  smoothed_t  smoothed_due[$];
  int         items_queued = 0;
  int         items_taken = 0;
  int         mismatches = 0;
  int         cycles = 0;
  int         in_idle_pct = 0;
  int         out_stall_pct = 0;
  int         hold_from = 32'h7FFF_FFFF;
  int         hold_left = 0;
  bit         hold_fired = 1'b0;
  bit         in_took = 1'b0;

  // Predictor state: line stores, window, raster position, registers.
  sample_t             older_row[MAX_WIDTH_DEF];
  sample_t             newer_row[MAX_WIDTH_DEF];
  sample_t             window[9];
  int                  row_pos = 0;
  int                  col_pos = 0;
  logic [CFG_BITS-1:0] width_reg = CFG_BITS'(GRID_WIDTH_RESET);
  logic [CFG_BITS-1:0] height_reg = CFG_BITS'(GRID_HEIGHT_RESET);

  box_filter_3x3_grid dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_out  (out_sample_out),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Effective grid dimension: registers below the floor or above the store
  // size are used clamped.
  function automatic int clamp_dim(logic [CFG_BITS-1:0] v, int hi);
    if (v < GRID_MIN) return GRID_MIN;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic void push_due(sample_t v, int r, int c, logic done, logic last);
    smoothed_t e;
    e.value = v;
    e.row   = COORD_BITS'(r);
    e.col   = COORD_BITS'(c);
    e.last  = last;
    e.done  = done;
    smoothed_due.push_back(e);
  endfunction

  // Advance the filter by one raster sample and queue the results it releases.
  function automatic void filter_step(sample_t s);
    int      w, h, r, c, sum, n, k;
    sample_t above2, above1, center;
    bit      last_row, last_col;
    w = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    r = row_pos;
    c = col_pos;
    // rotate the column through both line stores
    above2 = older_row[c];
    above1 = newer_row[c];
    older_row[c] = above1;
    newer_row[c] = s;
    // shift the window left and load the new column on the right
    for (int i = 0; i < 3; i++) begin
      window[i*3]   = window[i*3+1];
      window[i*3+1] = window[i*3+2];
    end
    window[2] = above2;
    window[5] = above1;
    window[8] = s;
    if (r >= 1 && c >= 1) begin
      last_row = (r == h - 1);
      last_col = (c == w - 1);
      n = 1 + int'(last_col) + int'(last_row) + int'(last_row && last_col);
      if (r >= 2 && c >= 2) begin
        // mean of nine, rounded to nearest, halves away from zero
        sum = 0;
        foreach (window[i]) sum += window[i];
        if (sum >= 0) begin
          center = sample_t'((sum + 4) / 9);
        end else begin
          center = sample_t'(-((-sum + 4) / 9));
        end
      end else begin
        center = window[4];
      end
      k = 1;
      push_due(center, r - 1, c - 1, 1'b0, k == n);
      if (last_col) begin
        k++;
        push_due(window[5], r - 1, c, 1'b0, k == n);
      end
      if (last_row) begin
        k++;
        push_due(window[7], r, c - 1, 1'b0, k == n);
        if (last_col) begin
          k++;
          push_due(window[8], r, c, 1'b1, k == n);
        end
      end
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic signed [31:0] want_v,
                             logic signed [31:0] got_v, smoothed_t at);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s at (%0d,%0d): expected %0d, got %0d",
                                name, at.row, at.col, want_v, got_v));
  endtask

  // Draw a sample: extremes, values near zero for the rounding, or any pattern.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: return sample_t'(int'($urandom_range(0, 16)) - 8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic void queue_sample(sample_t v);
    samples_to_send.push_back('{1'b0, v});
    items_queued++;
  endfunction

  // Queue random samples; pause_at places a drain marker before that item.
  function automatic void queue_random(int count, int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) samples_to_send.push_back('{1'b1, sample_t'(0)});
      queue_sample(pick_sample());
    end
  endfunction

  function automatic void set_idle(int mode);
    case (mode)
      1: begin in_idle_pct = 55; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 55; end
      3: begin in_idle_pct = 9;  out_stall_pct = 9;  end
      default: begin in_idle_pct = 0; out_stall_pct = 0; end
    endcase
  endfunction

  // Drive one register write; the caller drops the write enable after the last.
  // Any write restarts the grid at row 0, column 0.
  task automatic write_reg(cfg_idx_t idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_BITS'(value);
    @(negedge clk);
    if (idx == CFG_GRID_WIDTH) begin
      width_reg = CFG_BITS'(value);
    end else begin
      height_reg = CFG_BITS'(value);
    end
    row_pos = 0;
    col_pos = 0;
  endtask

  // Wait until every queued item is taken and every result has come, then let
  // items that release no result drain out of the pipeline.
  task automatic wait_idle();
    while (items_taken != items_queued || smoothed_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sender: advance to the next item once the current one is taken, hold it
  // while stalled, and idle at random between items.
  always @(negedge clk) begin : sender
    feed_item_t head;
    if (!in_valid || in_took) begin
      if (samples_to_send.size() != 0 && samples_to_send[0].pause &&
          smoothed_due.size() == 0)
        void'(samples_to_send.pop_front());
      if (samples_to_send.size() != 0 && !samples_to_send[0].pause &&
          $urandom_range(0, 99) >= in_idle_pct) begin
        head = samples_to_send.pop_front();
        in_valid     <= 1'b1;
        in_sample_in <= head.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, or hold off for a long stretch once the chosen
  // item count is reached so the block fills up and stalls its input.
  always @(negedge clk) begin : receiver
    if (!hold_fired && items_taken >= hold_from) begin
      hold_fired = 1'b1;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end
  end

  // Monitor: predict on every accepted item, check every accepted result
  // against the oldest one due.
  always @(posedge clk) begin : observe
    smoothed_t want;
    in_took = rst_n && in_valid && in_stall === 1'b0;
    if (in_took) begin
      items_taken++;
      filter_step(in_sample_in);
    end
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (smoothed_due.size() == 0) begin
        report_mismatch($sformatf("result at (%0d,%0d) with nothing due", out_row, out_col));
      end else begin
        want = smoothed_due.pop_front();
        check_field("sample", want.value, out_sample_out, want);
        check_field("row", want.row, out_row, want);
        check_field("col", want.col, out_col, want);
        check_field("last_of_run", want.last, out_last_of_run, want);
        check_field("frame_done", want.done, out_frame_done, want);
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int rand_items, rand_phases, cells, n, pick, w, h;
    rand_items  = 0;
    rand_phases = 0;
    foreach (older_row[i]) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    foreach (window[i]) window[i] = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Smallest grid from under-range registers, three times over to cross the
    // wrap: all maximum, all minimum, then a neighborhood whose mean must
    // round toward -1.
    set_idle(0);
    write_reg(CFG_GRID_WIDTH, 2);
    write_reg(CFG_GRID_HEIGHT, 1);
    cfg_we <= 1'b0;
    repeat (9) queue_sample(SAMPLE_MAX);
    repeat (9) queue_sample(SAMPLE_MIN);
    repeat (5) queue_sample(sample_t'(-1));
    repeat (4) queue_sample(sample_t'(0));
    wait_idle();

    // Sender idling: one whole 5 x 4 grid, held once midway until all
    // results are in.
    set_idle(1);
    write_reg(CFG_GRID_WIDTH, 5);
    write_reg(CFG_GRID_HEIGHT, 4);
    cfg_we <= 1'b0;
    queue_random(5 * 4, 10);
    wait_idle();

    // Receiver stalling: over-range height on the narrowest width, fed only
    // partway so no early last row may appear.
    set_idle(2);
    write_reg(CFG_GRID_WIDTH, GRID_MIN);
    write_reg(CFG_GRID_HEIGHT, 511);
    cfg_we <= 1'b0;
    queue_random(GRID_MIN * 8, -1);
    wait_idle();

    // Both sides idling a little: one whole 4 x 5 grid.
    set_idle(3);
    write_reg(CFG_GRID_WIDTH, 4);
    write_reg(CFG_GRID_HEIGHT, 5);
    cfg_we <= 1'b0;
    queue_random(4 * 5, -1);
    wait_idle();

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender keeps offering items, then the sender pauses for a full drain.
    set_idle(0);
    write_reg(CFG_GRID_WIDTH, 8);
    write_reg(CFG_GRID_HEIGHT, 6);
    cfg_we <= 1'b0;
    hold_from = items_queued + 12;
    queue_random(8 * 6, 30);
    wait_idle();

    // Random phases: mostly small grids, sometimes clamped, often ending
    // mid-grid so the next register write restarts the raster.
    while (rand_items < 24 || rand_phases < 4) begin
      set_idle(rand_phases % 4);
      pick = $urandom_range(0, 9);
      w = (pick < 7) ? $urandom_range(3, 8) :
          (pick < 9) ? $urandom_range(0, 2) : $urandom_range(256, 511);
      pick = $urandom_range(0, 9);
      h = (pick < 7) ? $urandom_range(3, 6) :
          (pick < 9) ? $urandom_range(0, 2) : $urandom_range(257, 511);
      case ($urandom_range(0, 4))
        0: write_reg(CFG_GRID_WIDTH, w);
        1: write_reg(CFG_GRID_HEIGHT, h);
        default: begin
          write_reg(CFG_GRID_HEIGHT, h);
          write_reg(CFG_GRID_WIDTH, w);
        end
      endcase
      cfg_we <= 1'b0;
      cells = clamp_dim(width_reg, MAX_WIDTH_DEF) * clamp_dim(height_reg, MAX_HEIGHT);
      n = (cells <= 16 && $urandom_range(0, 1) == 1) ? cells : $urandom_range(4, 16);
      queue_random(n, (n > 1 && $urandom_range(0, 9) < 4) ? $urandom_range(1, n - 1) : -1);
      rand_items += n;
      rand_phases++;
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/bxf_pkg.sv
hdl/bxf_ram.sv
hdl/bxf_div9.sv
hdl/box_filter_3x3_grid.sv
hdl/bxf_checker.sv
tb/sv/box_filter_3x3_grid_test.sv
